[design/fcf_pkg.sv]
// fcf_pkg: shared types and constants of the FIR convolution filter.
// Depends on nothing; used by fcf_mac, fcf_sat and fir_convolution_filter.
package fcf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int TAP_IDX_W = 7;
    localparam int TAP_CNT_W = 8;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int FRAC_BITS = 15;
    localparam int SAT_MAX   = 32767;
    localparam int SAT_MIN   = -32768;

    // action codes of an input beat
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_FILTER = 1'b1;

    // result of the truncate / saturate stage
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       clip;
    } t_sat_res;

endpackage

[design/fir_convolution_filter.sv]
// fir_convolution_filter: direct-form FIR filter, one shared MAC under a sequencer.
// Depends on fcf_pkg, fcf_mac and fcf_sat.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+------------------------------------------
//  input   | i_in_valid  | o_in_stall  | i_action i_tap_index i_coefficient
//          |             |             | i_sample i_block_start
//  output  | o_out_valid | i_out_stall | o_filtered_sample o_clipped
//  config  | i_cfg_we    | -           | i_cfg_wdata (tap_count)
//
// A sample beat runs taps = min(tap_count, samples since block start, MAX_TAPS) products
// through the single MAC, which steps one tap a cycle, before its result is loaded.
// Synchronous active-low reset; no clearing pass, the fill count hides stale history.
// The block stalls its input while a sample is in work; a finished result waits in
// the output register while a stalled receiver holds it, and new beats are then taken.
module fir_convolution_filter #(
    parameter int MAX_TAPS = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [fcf_pkg::TAP_CNT_W-1:0]          i_cfg_wdata,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_action,
    input  logic [fcf_pkg::TAP_IDX_W-1:0]          i_tap_index,
    input  logic signed [fcf_pkg::COEF_W-1:0]      i_coefficient,
    input  logic signed [fcf_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                                   i_block_start,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [fcf_pkg::SAMPLE_W-1:0]    o_filtered_sample,
    output logic                                   o_clipped
);
    import fcf_pkg::*;

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int IW    = (AW > TAP_IDX_W) ? AW : TAP_IDX_W;
    localparam int ACC_W = PROD_W + ((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 0);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    // memories
    logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
    logic signed [COEF_W-1:0]   tap_mem  [MAX_TAPS];

    t_state                     r_state;
    logic [TAP_CNT_W-1:0]       r_tap_count;
    logic [AW-1:0]              r_wr_ptr;
    logic [AW-1:0]              r_rd_ptr;
    logic [CW-1:0]              r_vcnt;
    logic [CW-1:0]              r_taps;
    logic [CW-1:0]              r_issue;
    logic                       r_rd_vld;
    logic signed [SAMPLE_W-1:0] r_hist_q;
    logic signed [COEF_W-1:0]   r_coef_q;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_value;
    logic                       r_out_clip;

    logic                       w_accept;
    logic                       w_acc_write;
    logic                       w_acc_sample;
    logic                       w_idx_ok;
    logic [IW-1:0]              w_idx_ext;
    logic                       w_issue;
    logic [CW-1:0]              n_vcnt;
    logic [CW-1:0]              n_taps;
    logic [AW-1:0]              n_wr_ptr;
    logic [AW-1:0]              n_rd_ptr;
    logic                       w_prod_vld;
    logic signed [ACC_W-1:0]    w_acc;
    t_sat_res                   w_sat;
    logic                       w_load;

    // input handshake decode
    assign o_in_stall   = (r_state != S_IDLE);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_acc_write  = w_accept && (i_action == ACT_WRITE);
    assign w_acc_sample = w_accept && (i_action == ACT_FILTER);
    assign w_idx_ext    = IW'(i_tap_index);
    assign w_idx_ok     = (32'(i_tap_index) < MAX_TAPS);
    assign w_issue      = (r_state == S_RUN) && (r_issue != r_taps);
    assign w_load       = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    // fill count, tap count in use and pointer steps
    always_comb begin
        n_vcnt = i_block_start ? '0 : r_vcnt;
        if (32'(n_vcnt) < MAX_TAPS) begin
            n_vcnt = n_vcnt + 1'b1;
        end
        n_taps   = (32'(r_tap_count) < 32'(n_vcnt)) ? CW'(r_tap_count) : n_vcnt;
        n_wr_ptr = (r_wr_ptr == AW'(MAX_TAPS - 1)) ? '0 : (r_wr_ptr + 1'b1);
        n_rd_ptr = (r_rd_ptr == '0) ? AW'(MAX_TAPS - 1) : (r_rd_ptr - 1'b1);
    end

    // tap table: write on a coefficient beat, read one tap per issue
    always_ff @(posedge i_clk) begin
        if (w_acc_write && w_idx_ok) begin
            tap_mem[w_idx_ext[AW-1:0]] <= i_coefficient;
        end
        if (w_issue) begin
            r_coef_q <= tap_mem[r_issue[AW-1:0]];
        end
    end

    // sample history: push on a sample beat, read newest first
    always_ff @(posedge i_clk) begin
        if (w_acc_sample) begin
            hist_mem[r_wr_ptr] <= i_sample;
        end
        if (w_issue) begin
            r_hist_q <= hist_mem[r_rd_ptr];
        end
    end

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap_count <= TAP_CNT_W'(1);
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_vcnt      <= '0;
            r_taps      <= '0;
            r_issue     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_wdata;
            end
            r_rd_vld <= w_issue;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc_sample) begin
                        r_wr_ptr <= n_wr_ptr;
                        r_rd_ptr <= r_wr_ptr;
                        r_vcnt   <= n_vcnt;
                        r_taps   <= n_taps;
                        r_issue  <= '0;
                        r_state  <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_issue) begin
                        r_issue  <= r_issue + 1'b1;
                        r_rd_ptr <= n_rd_ptr;
                    end else if (!r_rd_vld && !w_prod_vld) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value <= w_sat.value;
            r_out_clip  <= w_sat.clip;
        end
    end

    fcf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (w_acc_sample),
        .i_vld      (r_rd_vld),
        .i_sample   (r_hist_q),
        .i_coef     (r_coef_q),
        .o_prod_vld (w_prod_vld),
        .o_acc      (w_acc)
    );

    fcf_sat #(
        .ACC_W (ACC_W)
    ) u_sat (
        .i_acc (w_acc),
        .o_res (w_sat)
    );

    assign o_out_valid       = r_out_valid;
    assign o_filtered_sample = r_out_value;
    assign o_clipped         = r_out_clip;

    // issue counter never passes the tap count in use
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue <= r_taps)
        else $error("issue counter beyond tap count");

    // fill count stays within the history depth
    a_vcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_vcnt) <= MAX_TAPS)
        else $error("fill count beyond history depth");

    // MAC pipeline is empty whenever the block is idle
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_rd_vld && !w_prod_vld))
        else $error("MAC pipeline busy while idle");

    // a sample beat always starts a run
    a_sample_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_sample |=> (r_state == S_RUN))
        else $error("sample beat did not start a run");

    // a clipped result sits at a rail
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            ((o_filtered_sample == SAMPLE_W'(SAT_MAX)) ||
             (o_filtered_sample == SAMPLE_W'(SAT_MIN))))
        else $error("clipped result off the rails");

endmodule

[design/fcf_mac.sv]
// fcf_mac: shared multiply-accumulate unit, one tap product per cycle.
// Depends on fcf_pkg for sample and coefficient widths.
module fcf_mac #(
    parameter int ACC_W = 41
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_clr,
    input  logic                                 i_vld,
    input  logic signed [fcf_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic signed [fcf_pkg::COEF_W-1:0]    i_coef,
    output logic                                 o_prod_vld,
    output logic signed [ACC_W-1:0]              o_acc
);
    import fcf_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;

    // product valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_vld;
        end
    end

    // registered product, then accumulate
    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_prod <= i_sample * i_coef;
        end
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_prod_vld = r_prod_vld;
    assign o_acc      = r_acc;

endmodule

[design/fcf_sat.sv]
// fcf_sat: shift right by the fraction width toward zero, saturate to int16.
// Depends on fcf_pkg for t_sat_res and the saturation limits.
module fcf_sat #(
    parameter int ACC_W = 41
) (
    input  logic signed [ACC_W-1:0] i_acc,
    output fcf_pkg::t_sat_res       o_res
);
    import fcf_pkg::*;

    localparam logic signed [ACC_W-1:0] L_MAX  = ACC_W'(SAT_MAX);
    localparam logic signed [ACC_W-1:0] L_MIN  = ACC_W'(SAT_MIN);
    localparam logic signed [ACC_W-1:0] L_BIAS = ACC_W'((2 ** FRAC_BITS) - 1);

    logic signed [ACC_W-1:0] w_adj;
    logic signed [ACC_W-1:0] w_shift;

    // bias negatives so the arithmetic shift truncates toward zero
    always_comb begin
        w_adj   = i_acc[ACC_W-1] ? (i_acc + L_BIAS) : i_acc;
        w_shift = w_adj >>> FRAC_BITS;
    end

    // clamp to the int16 range
    always_comb begin
        priority if (w_shift > L_MAX) begin
            o_res.value = SAMPLE_W'(SAT_MAX);
            o_res.clip  = 1'b1;
        end else if (w_shift < L_MIN) begin
            o_res.value = SAMPLE_W'(SAT_MIN);
            o_res.clip  = 1'b1;
        end else begin
            o_res.value = w_shift[SAMPLE_W-1:0];
            o_res.clip  = 1'b0;
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking testbench of fir_convolution_filter.
// Depends on fcf_pkg and fir_convolution_filter; directed table first, then
// random coefficient loads and sample blocks checked by a local FIR predictor.
module tb;

    import fcf_pkg::*;

    localparam int MAX_TAPS   = 128;
    localparam int RAND_BEATS = 1300;
    localparam int COEF_MAX   = 2 ** (COEF_W - 1) - 1;
    localparam int COEF_MIN   = -(2 ** (COEF_W - 1));
    localparam int UNITY      = 2 ** FRAC_BITS;
    localparam int DRAIN_MAX  = 5000;
    localparam int SETTLE     = 10;

    typedef enum bit {ROW_BEAT, ROW_CFG} t_row_kind;

    // one directed or random row; exp_* only count when typed is set
    typedef struct {
        t_row_kind                  kind;
        logic                       action;
        logic [TAP_IDX_W-1:0]       idx;
        logic signed [COEF_W-1:0]   coef;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       start;
        logic [TAP_CNT_W-1:0]       cfg_val;
        bit                         typed;
        logic signed [SAMPLE_W-1:0] exp_val;
        logic                       exp_clip;
    } t_beat;

    bit                         i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [TAP_CNT_W-1:0]       i_cfg_wdata;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_action;
    logic [TAP_IDX_W-1:0]       i_tap_index;
    logic signed [COEF_W-1:0]   i_coefficient;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_block_start;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [SAMPLE_W-1:0] o_filtered_sample;
    logic                       o_clipped;

    // predictor state
    logic signed [SAMPLE_W-1:0] hist [MAX_TAPS];
    bit [TAP_IDX_W-1:0]         hist_ptr;
    int                         hist_fill;
    logic signed [COEF_W-1:0]   coef_tbl [MAX_TAPS];
    bit [TAP_CNT_W-1:0]         tap_cnt;

    t_sat_res fir_out_q [$];
    t_sat_res got_exp;
    t_beat    dir_tbl [$];

    int  errors;
    int  beats_sent;
    int  results_checked;
    int  clips_seen;
    int  cfg_writes;
    int  rand_beats;
    bit  no_gaps;

    fir_convolution_filter #(.MAX_TAPS(MAX_TAPS)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_tap_index      (i_tap_index),
        .i_coefficient    (i_coefficient),
        .i_sample         (i_sample),
        .i_block_start    (i_block_start),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_filtered_sample(o_filtered_sample),
        .o_clipped        (o_clipped)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #6_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // FIR predictor: push sample, convolve, truncate toward zero, saturate
    function automatic t_sat_res fir_predict(input logic signed [SAMPLE_W-1:0] x,
                                             input logic start);
        t_sat_res           r;
        longint             acc;
        longint             y;
        int                 n;
        bit [TAP_IDX_W-1:0] pos;
        if (start)
            hist_fill = 0;
        hist[hist_ptr] = x;
        hist_ptr = hist_ptr + 1'b1;
        if (hist_fill < MAX_TAPS)
            hist_fill++;
        n = int'(tap_cnt);
        if (n > hist_fill)
            n = hist_fill;
        if (n > MAX_TAPS)
            n = MAX_TAPS;
        acc = 0;
        for (int k = 0; k < n; k++) begin
            pos = TAP_IDX_W'(int'(hist_ptr) - 1 - k);
            acc += longint'(hist[pos]) * longint'(coef_tbl[k]);
        end
        // integer division truncates toward zero
        y = acc / (longint'(1) << FRAC_BITS);
        r.clip = 1'b0;
        if (y > SAT_MAX) begin
            y = SAT_MAX;
            r.clip = 1'b1;
        end else if (y < SAT_MIN) begin
            y = SAT_MIN;
            r.clip = 1'b1;
        end
        r.value = SAMPLE_W'(y);
        return r;
    endfunction

    // directed row builders
    function automatic t_beat wr(input int idx, input int c);
        t_beat b;
        b = '{kind: ROW_BEAT, action: ACT_WRITE, default: '0};
        b.idx  = TAP_IDX_W'(idx);
        b.coef = COEF_W'(c);
        return b;
    endfunction

    function automatic t_beat smp(input int s, input bit st);
        t_beat b;
        b = '{kind: ROW_BEAT, action: ACT_FILTER, default: '0};
        b.smp   = SAMPLE_W'(s);
        b.start = st;
        return b;
    endfunction

    function automatic t_beat smp_x(input int s, input bit st, input int y, input bit clip);
        t_beat b;
        b = smp(s, st);
        b.typed    = 1'b1;
        b.exp_val  = SAMPLE_W'(y);
        b.exp_clip = clip;
        return b;
    endfunction

    function automatic t_beat cfg(input int n);
        t_beat b;
        b = '{kind: ROW_CFG, default: '0};
        b.cfg_val = TAP_CNT_W'(n);
        return b;
    endfunction

    // random field values: full range, small, or extremes
    function automatic logic signed [COEF_W-1:0] rand_coef();
        logic signed [COEF_W-1:0] c;
        case ($urandom_range(2))
            0: c = COEF_W'($urandom);
            1: c = COEF_W'(int'($urandom_range(8192)) - 4096);
            default: begin
                case ($urandom_range(5))
                    0: c = COEF_W'(COEF_MAX);
                    1: c = COEF_W'(COEF_MIN);
                    2: c = '0;
                    3: c = COEF_W'(UNITY);
                    4: c = COEF_W'(-UNITY);
                    default: c = '1;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(3))
            0, 1: s = SAMPLE_W'($urandom);
            2: s = SAMPLE_W'(int'($urandom_range(2000)) - 1000);
            default: begin
                case ($urandom_range(3))
                    0: s = SAMPLE_W'(SAT_MAX);
                    1: s = SAMPLE_W'(SAT_MIN);
                    2: s = '0;
                    default: s = '1;
                endcase
            end
        endcase
        return s;
    endfunction

    // random beat; fields the action does not use carry junk
    function automatic t_beat random_beat(input bit is_write, input bit start);
        t_beat b;
        b = '{kind: ROW_BEAT, default: '0};
        b.action = is_write ? ACT_WRITE : ACT_FILTER;
        b.idx    = TAP_IDX_W'($urandom_range(MAX_TAPS - 1));
        b.coef   = rand_coef();
        b.smp    = rand_sample();
        b.start  = is_write ? 1'($urandom) : start;
        return b;
    endfunction

    // mostly small tap counts; the largest and the saturating ones now and then
    function automatic int pick_tap_count();
        int r;
        r = $urandom_range(99);
        if (r < 50)      return $urandom_range(8, 1);
        else if (r < 70) return $urandom_range(32, 9);
        else if (r < 80) return $urandom_range(MAX_TAPS - 1, 33);
        else if (r < 87) return MAX_TAPS;
        else if (r < 92) return $urandom_range(255, MAX_TAPS + 1);
        else if (r < 96) return 0;
        else             return 1;
    endfunction

    // drive one input beat and update the predictor when it is taken
    task automatic drive_beat(input t_beat b);
        t_sat_res res;
        while (!no_gaps && $urandom_range(99) < 9) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= b.action;
        i_tap_index   <= b.idx;
        i_coefficient <= b.coef;
        i_sample      <= b.smp;
        i_block_start <= b.start;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        if (b.action == ACT_WRITE) begin
            coef_tbl[b.idx] = b.coef;
        end else begin
            res = fir_predict(b.smp, b.start);
            if (b.typed) begin
                res.value = b.exp_val;
                res.clip  = b.exp_clip;
            end
            fir_out_q.push_back(res);
        end
        beats_sent++;
        @(negedge i_clk);
    endtask

    // wait for every expected result, bounded
    task automatic wait_drain();
        int n;
        n = 0;
        while (fir_out_q.size() != 0 && n < DRAIN_MAX) begin
            @(negedge i_clk);
            n++;
        end
        if (fir_out_q.size() != 0) begin
            $error("%0d expected results never arrived", fir_out_q.size());
            errors++;
            fir_out_q.delete();
        end
    endtask

    // tap_count is written only with the block idle
    task automatic set_tap_count(input int n);
        i_in_valid <= 1'b0;
        wait_drain();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= TAP_CNT_W'(n);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tap_cnt = TAP_CNT_W'(n);
        cfg_writes++;
    endtask

    // receiver stall
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1)
            i_out_stall <= !no_gaps && ($urandom_range(99) < 9);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (fir_out_q.size() == 0) begin
                $error("result beat with nothing expected: filtered_sample %0d",
                       o_filtered_sample);
                errors++;
            end else begin
                got_exp = fir_out_q.pop_front();
                results_checked++;
                if (o_filtered_sample !== got_exp.value) begin
                    $error("filtered_sample: expected %0d, got %0d",
                           got_exp.value, o_filtered_sample);
                    errors++;
                end
                if (o_clipped !== got_exp.clip) begin
                    $error("clipped: expected %0d, got %0d", got_exp.clip, o_clipped);
                    errors++;
                end
                if (got_exp.clip)
                    clips_seen++;
            end
        end
    end

    // stimulus
    initial begin
        int  plen;
        int  n;
        bit  is_write;
        bit  start;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_WRITE;
        i_tap_index   <= '0;
        i_coefficient <= '0;
        i_sample      <= '0;
        i_block_start <= 1'b0;
        i_out_stall   <= 1'b0;
        for (int k = 0; k < MAX_TAPS; k++) begin
            hist[k]     = '0;
            coef_tbl[k] = '0;
        end
        hist_ptr  = '0;
        hist_fill = 0;
        tap_cnt   = TAP_CNT_W'(1);
        no_gaps   = 1'b0;

        // extremes, rounding toward zero, zero and oversized tap counts
        dir_tbl = {
            wr(0, UNITY),
            smp_x(1000, 1, 1000, 0),
            smp_x(SAT_MIN, 0, SAT_MIN, 0),
            smp_x(SAT_MAX, 0, SAT_MAX, 0),
            wr(0, COEF_MAX),
            smp_x(SAT_MAX, 1, SAT_MAX, 1),
            smp_x(SAT_MIN, 0, SAT_MIN, 1),
            wr(0, COEF_MIN),
            smp_x(SAT_MIN, 1, SAT_MAX, 1),
            smp_x(SAT_MAX, 0, SAT_MIN, 1),
            wr(0, -1),
            smp_x(1, 1, 0, 0),
            smp_x(SAT_MIN, 0, 1, 0),
            wr(0, UNITY / 2),
            smp_x(12345, 1, 6172, 0),
            smp_x(-12345, 0, -6172, 0),
            cfg(0),
            smp_x(SAT_MAX, 1, 0, 0),
            smp_x(SAT_MIN, 0, 0, 0),
            wr(1, UNITY),
            cfg(255),
            smp(100, 1),
            smp(200, 0),
            cfg(2),
            smp(-300, 0)
        };

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tbl[r]) begin
            if (dir_tbl[r].kind == ROW_CFG)
                set_tap_count(int'(dir_tbl[r].cfg_val));
            else
                drive_beat(dir_tbl[r]);
        end

        // full table load, then a long block that fills the whole history
        set_tap_count(MAX_TAPS);
        for (int k = 0; k < MAX_TAPS; k++) begin
            drive_beat(wr(k, int'(rand_coef())));
            rand_beats++;
        end
        for (int k = 0; k < 150; k++) begin
            drive_beat(random_beat(1'b0, k == 0));
            rand_beats++;
        end

        // random phases, one tap count each
        while (rand_beats < RAND_BEATS) begin
            n = pick_tap_count();
            set_tap_count(n);
            plen = (n > 32) ? $urandom_range(25, 10) : $urandom_range(60, 20);
            for (int k = 0; k < plen; k++) begin
                is_write = $urandom_range(99) < 15;
                start    = (k == 0 && $urandom_range(1) == 1) || $urandom_range(99) < 4;
                drive_beat(random_beat(is_write, start));
                rand_beats++;
                no_gaps = rand_beats >= 500 && rand_beats < 800;
            end
        end

        i_in_valid <= 1'b0;
        wait_drain();
        repeat (SETTLE) @(negedge i_clk);

        $display("run covered %0d input beats, %0d results checked (%0d clipped)",
                 beats_sent, results_checked, clips_seen);
        $display("tap_count written %0d times, %0d errors", cfg_writes, errors);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
